// File: sv/pqe_pkg.sv
`timescale 1ns / 1ps

package pqe_pkg;

  // default sizes of the stored codebook
  localparam int MAX_SUBSPACES_DEF = 16;
  localparam int CODEBOOK_SIZE_DEF = 256;
  localparam int MAX_SUB_DIM_DEF   = 16;

  // component format, signed q8.8
  localparam int VALUE_BITS = 16;

  // width of an effective count, enough for the largest parameter value
  localparam int CNT_W = 7;

  // operation codes
  localparam logic OP_CB_WRITE = 1'b0;
  localparam logic OP_QUERY    = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_NUM_SUBSPACES  = 2'd0;
  localparam logic [1:0] REG_SUB_DIM        = 2'd1;
  localparam logic [1:0] REG_CODEBOOK_READY = 2'd2;

  typedef struct packed {
    logic                   operation;
    logic [3:0]             sub_index;
    logic [7:0]             centroid_index;
    logic [3:0]             dim_index;
    logic signed [15:0]     value;
  } in_req_t;

  typedef struct packed {
    logic [7:0] code;
    logic [3:0] code_subspace;
    logic       last;
  } out_res_t;

  // travels with each scan read through the distance pipeline
  typedef struct packed {
    logic       valid;
    logic       first_dim;
    logic       last_dim;
    logic       last_cent;
    logic [7:0] cent;
  } scan_tag_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

endpackage

// File: sv/product_quantization_encoder.sv
`timescale 1ns / 1ps

// Product-quantization encoder. A request with operation 0 stores one q8.8
// component of one centroid; a request with operation 1 stores one query
// component. The query component at position sub_dim-1 of a subspace, with
// codebook_ready set, starts a scan of every centroid of that subspace and
// raises busy. The scan reads one codebook word and one query word per cycle
// from the two memories, and the code appears once the last read has passed
// through the read registers and the distance pipeline, on the
// out_ ports for one cycle with out_valid high; the receiver must take it
// then. busy falls at the end of that cycle, and the next request is taken
// once busy is low. Any other request is taken whenever busy is low.
// Configuration must be written only
// while busy is low. There is no clearing pass: codebook entries must be
// written before a scan reads them.
module product_quantization_encoder #(
  parameter int MAX_SUBSPACES = pqe_pkg::MAX_SUBSPACES_DEF,
  parameter int CODEBOOK_SIZE = pqe_pkg::CODEBOOK_SIZE_DEF,
  parameter int MAX_SUB_DIM   = pqe_pkg::MAX_SUB_DIM_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  pqe_pkg::in_req_t  in_data,
  output logic              out_valid,
  output pqe_pkg::out_res_t out_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [4:0]        cfg_wdata
);

  localparam int DIM_W = (MAX_SUB_DIM > 1) ? $clog2(MAX_SUB_DIM) : 1;
  localparam int CI_W  = $clog2(CODEBOOK_SIZE);

  pqe_pkg::state_t state_r, state_nxt;

  logic [4:0] num_subspaces_r;
  logic [4:0] sub_dim_r;
  logic       codebook_ready_r;

  logic [pqe_pkg::CNT_W-1:0] nsub_eff, dims_eff;
  logic [DIM_W-1:0] dim_r;
  logic [CI_W-1:0]  cent_r;
  logic [3:0]       scan_sub_r;
  logic             scan_last_r;

  logic accept, cb_we, q_we, scan_go, dim_last, cent_last;
  logic in_cb_range, in_q_range;
  pqe_pkg::scan_tag_t rd_tag, rd_tag_r;
  logic [pqe_pkg::VALUE_BITS-1:0] rd_cb, rd_q;
  logic       done;
  logic [7:0] best;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_subspaces_r  <= 5'd1;
      sub_dim_r        <= 5'd8;
      codebook_ready_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        pqe_pkg::REG_NUM_SUBSPACES:  num_subspaces_r  <= cfg_wdata;
        pqe_pkg::REG_SUB_DIM:        sub_dim_r        <= cfg_wdata;
        pqe_pkg::REG_CODEBOOK_READY: codebook_ready_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // effective counts: zero acts as one, large values saturate
  always_comb begin
    if (num_subspaces_r == 5'd0) begin
      nsub_eff = pqe_pkg::CNT_W'(1);
    end else if (32'(num_subspaces_r) > MAX_SUBSPACES) begin
      nsub_eff = pqe_pkg::CNT_W'(MAX_SUBSPACES);
    end else begin
      nsub_eff = pqe_pkg::CNT_W'(num_subspaces_r);
    end
    if (sub_dim_r == 5'd0) begin
      dims_eff = pqe_pkg::CNT_W'(1);
    end else if (32'(sub_dim_r) > MAX_SUB_DIM) begin
      dims_eff = pqe_pkg::CNT_W'(MAX_SUB_DIM);
    end else begin
      dims_eff = pqe_pkg::CNT_W'(sub_dim_r);
    end
  end

  // request decode
  assign accept      = start && !busy;
  assign in_cb_range = (32'(in_data.sub_index) < MAX_SUBSPACES) &&
                       (32'(in_data.centroid_index) < CODEBOOK_SIZE) &&
                       (32'(in_data.dim_index) < MAX_SUB_DIM);
  assign in_q_range  = (pqe_pkg::CNT_W'(in_data.sub_index) < nsub_eff) &&
                       (pqe_pkg::CNT_W'(in_data.dim_index) < dims_eff);
  assign cb_we   = accept && (in_data.operation == pqe_pkg::OP_CB_WRITE) && in_cb_range;
  assign q_we    = accept && (in_data.operation == pqe_pkg::OP_QUERY) && in_q_range;
  assign scan_go = q_we && codebook_ready_r &&
                   (pqe_pkg::CNT_W'(in_data.dim_index) == dims_eff - pqe_pkg::CNT_W'(1));

  // scan position
  assign dim_last  = (pqe_pkg::CNT_W'(dim_r) == dims_eff - pqe_pkg::CNT_W'(1));
  assign cent_last = (cent_r == CI_W'(CODEBOOK_SIZE - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pqe_pkg::ST_IDLE:  if (scan_go) state_nxt = pqe_pkg::ST_SCAN;
      pqe_pkg::ST_SCAN:  if (dim_last && cent_last) state_nxt = pqe_pkg::ST_DRAIN;
      pqe_pkg::ST_DRAIN: if (done) state_nxt = pqe_pkg::ST_IDLE;
      default:           state_nxt = pqe_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pqe_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // scan counters and the code's subspace
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r  <= '0;
      cent_r <= '0;
    end else if (scan_go) begin
      dim_r  <= '0;
      cent_r <= '0;
    end else if (state_r == pqe_pkg::ST_SCAN) begin
      if (dim_last) begin
        dim_r  <= '0;
        cent_r <= cent_r + CI_W'(1);
      end else begin
        dim_r <= dim_r + DIM_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_go) begin
      scan_sub_r  <= in_data.sub_index;
      scan_last_r <= (pqe_pkg::CNT_W'(in_data.sub_index) == nsub_eff - pqe_pkg::CNT_W'(1));
    end
  end

  // outputs
  always_comb begin
    busy            = (state_r != pqe_pkg::ST_IDLE);
    rd_tag.valid     = (state_r == pqe_pkg::ST_SCAN);
    rd_tag.first_dim = (dim_r == '0);
    rd_tag.last_dim  = dim_last;
    rd_tag.last_cent = cent_last;
    rd_tag.cent      = 8'(cent_r);
    out_valid              = done;
    out_data.code          = best;
    out_data.code_subspace = scan_sub_r;
    out_data.last          = scan_last_r;
  end

  pqe_store #(
    .MAX_SUBSPACES(MAX_SUBSPACES),
    .CODEBOOK_SIZE(CODEBOOK_SIZE),
    .MAX_SUB_DIM  (MAX_SUB_DIM)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .cb_we    (cb_we),
    .cb_wsub  (in_data.sub_index),
    .cb_wcent (in_data.centroid_index),
    .cb_wdim  (in_data.dim_index),
    .cb_wdata (in_data.value),
    .q_we     (q_we),
    .q_wdim   (in_data.dim_index),
    .q_wdata  (in_data.value),
    .rd_tag   (rd_tag),
    .rd_sub   (scan_sub_r),
    .rd_dim   (dim_r),
    .rd_tag_r (rd_tag_r),
    .rd_cb_r  (rd_cb),
    .rd_q_r   (rd_q)
  );

  pqe_dist #(
    .MAX_SUB_DIM(MAX_SUB_DIM)
  ) u_dist (
    .clk    (clk),
    .rst_n  (rst_n),
    .tag_in (rd_tag_r),
    .cb_val (rd_cb),
    .q_val  (rd_q),
    .done_r (done),
    .best_r (best)
  );

  // a code only leaves while draining the scan
  a_out_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == pqe_pkg::ST_DRAIN))
    else $error("code emitted outside drain");

  // one code per scan
  a_out_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("code strobe longer than one cycle");

  // a final query component with the codebook ready starts a scan
  a_scan_starts: assert property (@(posedge clk) disable iff (!rst_n)
    scan_go |=> (busy && (cent_r == '0) && (dim_r == '0)))
    else $error("scan did not start");

  // the last read of a scan moves to draining
  a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pqe_pkg::ST_SCAN && dim_last && cent_last) |=>
      (state_r == pqe_pkg::ST_DRAIN))
    else $error("scan end missed");

  // no codes while the codebook is not ready
  a_ready_gate: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> codebook_ready_r)
    else $error("code emitted without codebook ready");

endmodule

// File: sv/pqe_store.sv
`timescale 1ns / 1ps

module pqe_store #(
  parameter int MAX_SUBSPACES = pqe_pkg::MAX_SUBSPACES_DEF,
  parameter int CODEBOOK_SIZE = pqe_pkg::CODEBOOK_SIZE_DEF,
  parameter int MAX_SUB_DIM   = pqe_pkg::MAX_SUB_DIM_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // codebook write
  input  logic                                cb_we,
  input  logic [3:0]                          cb_wsub,
  input  logic [7:0]                          cb_wcent,
  input  logic [3:0]                          cb_wdim,
  input  logic [pqe_pkg::VALUE_BITS-1:0]      cb_wdata,
  // query component write
  input  logic                                q_we,
  input  logic [3:0]                          q_wdim,
  input  logic [pqe_pkg::VALUE_BITS-1:0]      q_wdata,
  // scan read
  input  pqe_pkg::scan_tag_t                  rd_tag,
  input  logic [3:0]                          rd_sub,
  input  logic [(MAX_SUB_DIM > 1 ? $clog2(MAX_SUB_DIM) : 1)-1:0] rd_dim,
  output pqe_pkg::scan_tag_t                  rd_tag_r,
  output logic [pqe_pkg::VALUE_BITS-1:0]      rd_cb_r,
  output logic [pqe_pkg::VALUE_BITS-1:0]      rd_q_r
);

  localparam int CB_DEPTH = MAX_SUBSPACES * CODEBOOK_SIZE * MAX_SUB_DIM;
  localparam int CB_AW    = $clog2(CB_DEPTH);
  localparam int DIM_W    = (MAX_SUB_DIM > 1) ? $clog2(MAX_SUB_DIM) : 1;

  logic [pqe_pkg::VALUE_BITS-1:0] cb_mem [CB_DEPTH];
  logic [pqe_pkg::VALUE_BITS-1:0] q_mem  [MAX_SUB_DIM];

  logic [CB_AW-1:0] cb_waddr;
  logic [CB_AW-1:0] cb_raddr;
  logic [DIM_W-1:0] q_waddr;

  // flat address: subspace, then centroid, then component
  assign cb_waddr = CB_AW'((32'(cb_wsub) * CODEBOOK_SIZE + 32'(cb_wcent)) * MAX_SUB_DIM
                           + 32'(cb_wdim));
  assign cb_raddr = CB_AW'((32'(rd_sub) * CODEBOOK_SIZE + 32'(rd_tag.cent)) * MAX_SUB_DIM
                           + 32'(rd_dim));
  assign q_waddr  = DIM_W'(32'(q_wdim));

  // codebook memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cb_we) begin
      cb_mem[cb_waddr] <= cb_wdata;
    end
    if (rd_tag.valid) begin
      rd_cb_r <= cb_mem[cb_raddr];
    end
  end

  // query subvector memory
  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[q_waddr] <= q_wdata;
    end
    if (rd_tag.valid) begin
      rd_q_r <= q_mem[rd_dim];
    end
  end

  // tag aligned with read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_tag_r <= '0;
    end else begin
      rd_tag_r <= rd_tag;
    end
  end

endmodule

// File: sv/pqe_dist.sv
`timescale 1ns / 1ps

module pqe_dist #(
  parameter int MAX_SUB_DIM = pqe_pkg::MAX_SUB_DIM_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  pqe_pkg::scan_tag_t             tag_in,
  input  logic [pqe_pkg::VALUE_BITS-1:0] cb_val,
  input  logic [pqe_pkg::VALUE_BITS-1:0] q_val,
  output logic                           done_r,
  output logic [7:0]                     best_r
);

  localparam int DIFF_W = pqe_pkg::VALUE_BITS + 1;
  localparam int SQ_W   = 2 * pqe_pkg::VALUE_BITS + 1;
  localparam int ACC_W  = SQ_W + $clog2(MAX_SUB_DIM);

  pqe_pkg::scan_tag_t tag_a_r, tag_b_r, tag_c_r;
  logic signed [DIFF_W-1:0]   diff_r, diff_nxt;
  logic signed [2*DIFF_W-1:0] prod;
  logic [SQ_W-1:0]            sq_r;
  logic [ACC_W-1:0]           acc_r, acc_nxt;
  logic [ACC_W-1:0]           best_d_r;
  logic                       take;

  // difference of sign-extended components
  assign diff_nxt = $signed({q_val[pqe_pkg::VALUE_BITS-1], q_val})
                  - $signed({cb_val[pqe_pkg::VALUE_BITS-1], cb_val});

  // square is never negative and fits in SQ_W bits
  assign prod = diff_r * diff_r;

  // running sum over the components of one centroid
  assign acc_nxt = (tag_b_r.first_dim ? '0 : acc_r) + ACC_W'(sq_r);

  // first centroid always taken, later ones only when strictly closer
  assign take = tag_c_r.valid && tag_c_r.last_dim &&
                ((tag_c_r.cent == 8'd0) || (acc_r < best_d_r));

  // payload stages
  always_ff @(posedge clk) begin
    diff_r <= diff_nxt;
    sq_r   <= prod[SQ_W-1:0];
    if (tag_b_r.valid) begin
      acc_r <= acc_nxt;
    end
    if (take) begin
      best_d_r <= acc_r;
      best_r   <= tag_c_r.cent;
    end
  end

  // control stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_a_r <= '0;
      tag_b_r <= '0;
      tag_c_r <= '0;
      done_r  <= 1'b0;
    end else begin
      tag_a_r <= tag_in;
      tag_b_r <= tag_a_r;
      tag_c_r <= tag_b_r;
      done_r  <= tag_c_r.valid && tag_c_r.last_dim && tag_c_r.last_cent;
    end
  end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int NSUB = pqe_pkg::MAX_SUBSPACES_DEF;
  localparam int NCENT = pqe_pkg::CODEBOOK_SIZE_DEF;
  localparam int NDIM = pqe_pkg::MAX_SUB_DIM_DEF;
  localparam int RANDOM_ITEMS = 600;

  typedef enum int {
    VAL_FULL,
    VAL_SMALL,
    VAL_EXTREME
  } val_mode_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  pqe_pkg::in_req_t  in_data;
  logic              out_valid;
  pqe_pkg::out_res_t out_data;
  logic              cfg_we;
  logic [1:0]        cfg_index;
  logic [4:0]        cfg_wdata;

  // shadow copy of the codebook, the query buffer and the registers
  logic signed [15:0] cb_word [NSUB][NCENT][NDIM];
  bit                 cb_set [NSUB][NCENT][NDIM];
  logic signed [15:0] query_word [NDIM];
  bit                 query_set [NDIM];
  logic [4:0]         nsub_reg;
  logic [4:0]         dim_reg;
  logic               ready_reg;

  pqe_pkg::out_res_t expected_codes[$];
  int       error_count;
  int       max_gap;
  int       random_count;

  product_quantization_encoder u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic int eff_subspaces();
    if (nsub_reg == 0) return 1;
    if (nsub_reg > NSUB) return NSUB;
    return int'(nsub_reg);
  endfunction

  function automatic int eff_sub_dim();
    if (dim_reg == 0) return 1;
    if (dim_reg > NDIM) return NDIM;
    return int'(dim_reg);
  endfunction

  function automatic pqe_pkg::in_req_t make_req(input logic op, input int sub, input int cent,
                                                input int dim, input logic signed [15:0] val);
    pqe_pkg::in_req_t r;
    r.operation = op;
    r.sub_index = 4'(sub);
    r.centroid_index = 8'(cent);
    r.dim_index = 4'(dim);
    r.value = val;
    return r;
  endfunction

  function automatic logic signed [15:0] pick_value(input val_mode_t mode);
    case (mode)
      VAL_SMALL: return 16'(int'($urandom_range(0, 4)) - 2);
      VAL_EXTREME: begin
        case ($urandom_range(0, 2))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          default: return 16'($urandom_range(0, 65535));
        endcase
      end
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // nearest centroid by exact squared distance, lowest index on a tie
  function automatic pqe_pkg::out_res_t encode_subspace(input int sub, input int nd,
                                                        input int ns);
    pqe_pkg::out_res_t res;
    longint unsigned best_sum;
    longint unsigned sum_sq;
    longint diff;
    int best;
    best = 0;
    best_sum = '1;
    for (int c = 0; c < NCENT; c++) begin
      sum_sq = 0;
      for (int j = 0; j < nd; j++) begin
        diff = longint'(query_word[j]) - longint'(cb_word[sub][c][j]);
        if (diff < 0) diff = -diff;
        sum_sq += diff * diff;
      end
      if (c == 0 || sum_sq < best_sum) begin
        best_sum = sum_sq;
        best = c;
      end
    end
    res.code = 8'(best);
    res.code_subspace = 4'(sub);
    res.last = (sub == ns - 1);
    return res;
  endfunction

  // a request that starts a scan may only read entries already written
  function automatic bit scan_allowed(input pqe_pkg::in_req_t r);
    int ns;
    int nd;
    ns = eff_subspaces();
    nd = eff_sub_dim();
    if (r.operation != pqe_pkg::OP_QUERY || !ready_reg || r.sub_index >= ns ||
        r.dim_index != nd - 1)
      return 1'b1;
    for (int j = 0; j < nd; j++) begin
      if (j != nd - 1 && !query_set[j]) return 1'b0;
      for (int c = 0; c < NCENT; c++)
        if (!cb_set[r.sub_index][c][j]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // send one request and fold it into the shadow state once accepted
  task automatic issue_request(input pqe_pkg::in_req_t r);
    int gap;
    int ns;
    int nd;
    gap = $urandom_range(0, max_gap);
    if (gap != 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    ns = eff_subspaces();
    nd = eff_sub_dim();
    if (r.operation == pqe_pkg::OP_CB_WRITE) begin
      cb_word[r.sub_index][r.centroid_index][r.dim_index] = r.value;
      cb_set[r.sub_index][r.centroid_index][r.dim_index] = 1'b1;
    end else if (r.sub_index < ns && r.dim_index < nd) begin
      query_word[r.dim_index] = r.value;
      query_set[r.dim_index] = 1'b1;
      if (r.dim_index == nd - 1 && ready_reg)
        expected_codes.push_back(encode_subspace(r.sub_index, nd, ns));
    end
  endtask

  // random request: a scan on unwritten entries turns into a codebook write
  task automatic send_checked(input pqe_pkg::in_req_t r);
    if (!scan_allowed(r)) r.operation = pqe_pkg::OP_CB_WRITE;
    random_count++;
    issue_request(r);
  endtask

  // wait until the block has delivered every pending code and gone quiet
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (expected_codes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [4:0] val);
    @(negedge clk);
    start <= 1'b0;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      pqe_pkg::REG_NUM_SUBSPACES: nsub_reg = val;
      pqe_pkg::REG_SUB_DIM: dim_reg = val;
      pqe_pkg::REG_CODEBOOK_READY: ready_reg = val[0];
      default: ;
    endcase
  endtask

  // defaults after reset: one subspace of eight, codebook not ready
  task automatic test_reset_state();
    for (int j = 0; j < 8; j++)
      issue_request(make_req(pqe_pkg::OP_QUERY, 0, 255, j, pick_value(VAL_EXTREME)));
    issue_request(make_req(pqe_pkg::OP_QUERY, 1, 0, 7, 16'sd100));
  endtask

  // subspace 0 at two components, subspaces 1 and the top one at one
  task automatic load_codebook();
    int nd;
    val_mode_t mode;
    for (int s = 0; s < NSUB; s++) begin
      if (s == 0) nd = 2;
      else if (s == 1 || s == NSUB - 1) nd = 1;
      else nd = 0;
      for (int c = 0; c < NCENT; c++)
        for (int j = 0; j < nd; j++) begin
          if (s == 1) mode = VAL_SMALL;
          else if (j >= 1) mode = VAL_EXTREME;
          else mode = VAL_FULL;
          issue_request(make_req(pqe_pkg::OP_CB_WRITE, s, c, j, pick_value(mode)));
        end
    end
  endtask

  // default subvector length still eight once ready, then a first code
  task automatic test_first_code();
    settle();
    write_reg(pqe_pkg::REG_CODEBOOK_READY, 5'd1);
    issue_request(make_req(pqe_pkg::OP_QUERY, 0, 0, 1, 16'sd0));
    write_reg(pqe_pkg::REG_SUB_DIM, 5'd2);
    issue_request(make_req(pqe_pkg::OP_QUERY, 0, 0, 1, 16'sd0));
  endtask

  // zero acts as one, oversized values saturate
  task automatic test_register_limits();
    settle();
    write_reg(pqe_pkg::REG_NUM_SUBSPACES, 5'd0);
    write_reg(pqe_pkg::REG_SUB_DIM, 5'd0);
    issue_request(make_req(pqe_pkg::OP_QUERY, 0, 0, 0, 16'sh0123));
    issue_request(make_req(pqe_pkg::OP_QUERY, 1, 0, 0, 16'sh0123));
    issue_request(make_req(pqe_pkg::OP_QUERY, 0, 0, 1, 16'sh0123));
    settle();
    write_reg(pqe_pkg::REG_NUM_SUBSPACES, 5'd31);
    write_reg(pqe_pkg::REG_SUB_DIM, 5'd1);
    issue_request(make_req(pqe_pkg::OP_QUERY, NSUB - 1, 0, 0, 16'sh7fff));
    settle();
    write_reg(pqe_pkg::REG_SUB_DIM, 5'd17);
    issue_request(make_req(pqe_pkg::OP_QUERY, 0, 128, 0, 16'sh8000));
    write_reg(pqe_pkg::REG_SUB_DIM, 5'd31);
    issue_request(make_req(pqe_pkg::OP_QUERY, 0, 128, 1, 16'sh8000));
    write_reg(pqe_pkg::REG_NUM_SUBSPACES, 5'd16);
    write_reg(pqe_pkg::REG_SUB_DIM, 5'd1);
    issue_request(make_req(pqe_pkg::OP_QUERY, NSUB - 1, 0, 0, 16'sh8000));
  endtask

  // equal distances resolve to the lowest centroid index
  task automatic test_ties();
    settle();
    write_reg(pqe_pkg::REG_NUM_SUBSPACES, 5'd2);
    write_reg(pqe_pkg::REG_SUB_DIM, 5'd1);
    issue_request(make_req(pqe_pkg::OP_CB_WRITE, 1, 201, 0, 16'sd5));
    issue_request(make_req(pqe_pkg::OP_CB_WRITE, 1, 200, 0, 16'sd5));
    issue_request(make_req(pqe_pkg::OP_QUERY, 1, 0, 0, 16'sd5));
    for (int s = 0; s < 2; s++)
      issue_request(make_req(pqe_pkg::OP_QUERY, s, 0, 0, pick_value(VAL_SMALL)));
  endtask

  // queries are stored but give no code while not ready
  task automatic test_ready_gating();
    settle();
    write_reg(pqe_pkg::REG_CODEBOOK_READY, 5'd0);
    write_reg(pqe_pkg::REG_NUM_SUBSPACES, 5'd2);
    write_reg(pqe_pkg::REG_SUB_DIM, 5'd2);
    for (int s = 0; s < 2; s++)
      for (int j = 0; j < 2; j++)
        issue_request(make_req(pqe_pkg::OP_QUERY, s, 0, j, pick_value(VAL_FULL)));
    settle();
    write_reg(pqe_pkg::REG_CODEBOOK_READY, 5'd1);
    issue_request(make_req(pqe_pkg::OP_QUERY, 0, 0, 1, pick_value(VAL_FULL)));
  endtask

  // random settings, well-formed query vectors mixed with noise
  task automatic test_random();
    int ns;
    int nd;
    int rounds;
    val_mode_t mode;
    pqe_pkg::in_req_t r;
    random_count = 0;
    while (random_count < RANDOM_ITEMS) begin
      settle();
      case ($urandom_range(0, 9))
        0: write_reg(pqe_pkg::REG_NUM_SUBSPACES, 5'd0);
        1: write_reg(pqe_pkg::REG_NUM_SUBSPACES, 5'($urandom_range(17, 31)));
        2: write_reg(pqe_pkg::REG_NUM_SUBSPACES, 5'(NSUB));
        default: write_reg(pqe_pkg::REG_NUM_SUBSPACES, 5'($urandom_range(1, 2)));
      endcase
      case ($urandom_range(0, 9))
        0: write_reg(pqe_pkg::REG_SUB_DIM, 5'd0);
        1: write_reg(pqe_pkg::REG_SUB_DIM, 5'($urandom_range(3, 31)));
        default: write_reg(pqe_pkg::REG_SUB_DIM, 5'($urandom_range(1, 2)));
      endcase
      write_reg(pqe_pkg::REG_CODEBOOK_READY, 5'($urandom_range(0, 7) != 0));
      max_gap = ($urandom_range(0, 2) == 0) ? 0 : 3;
      ns = eff_subspaces();
      nd = eff_sub_dim();
      rounds = (nd > 4) ? 1 : $urandom_range(1, 4);
      repeat (rounds) begin
        mode = val_mode_t'($urandom_range(0, 2));
        for (int s = 0; s < ns; s++)
          for (int j = 0; j < nd; j++) begin
            // noise: stray codebook write, out-of-range or early query
            if ($urandom_range(0, 5) == 0) begin
              r = make_req(pqe_pkg::OP_QUERY, $urandom_range(0, NSUB - 1),
                           $urandom_range(0, 255), $urandom_range(0, NDIM - 1),
                           pick_value(VAL_FULL));
              case ($urandom_range(0, 2))
                0: r.operation = pqe_pkg::OP_CB_WRITE;
                1: begin
                  if (ns < NSUB) r.sub_index = 4'($urandom_range(ns, NSUB - 1));
                  else if (nd < NDIM) r.dim_index = 4'($urandom_range(nd, NDIM - 1));
                end
                default: ;
              endcase
              send_checked(r);
            end
            // now and then a component goes missing
            if ($urandom_range(0, 15) != 0)
              send_checked(make_req(pqe_pkg::OP_QUERY, s, $urandom_range(0, 255), j,
                                    pick_value(mode)));
          end
      end
    end
    max_gap = 3;
  endtask

  // compare each code with the oldest expectation
  always @(posedge clk) begin : check_codes
    pqe_pkg::out_res_t want;
    if (out_valid === 1'b1) begin
      if (expected_codes.size() == 0) begin
        $error("code: expected none, got %0d for subspace %0d",
               out_data.code, out_data.code_subspace);
        error_count++;
      end else begin
        want = expected_codes.pop_front();
        if (out_data.code !== want.code) begin
          $error("code: expected %0d, got %0d", want.code, out_data.code);
          error_count++;
        end
        if (out_data.code_subspace !== want.code_subspace) begin
          $error("code_subspace: expected %0d, got %0d",
                 want.code_subspace, out_data.code_subspace);
          error_count++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_data.last);
          error_count++;
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = pqe_pkg::REG_NUM_SUBSPACES;
    cfg_wdata = '0;
    nsub_reg = 5'd1;
    dim_reg = 5'd8;
    ready_reg = 1'b0;
    error_count = 0;
    max_gap = 3;
    random_count = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    load_codebook();
    test_first_code();
    test_register_limits();
    test_ties();
    test_ready_gating();
    test_random();

    settle();
    repeat (300) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #500_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
